>>> hdl/rdc_pkg.sv
// Shared constants, types and reciprocal table for the radix digit converter.
`default_nettype none

package rdc_pkg;

   // Width of the value field on the request channel
   localparam int FIELD_BITS = 32;

   // Digit stack depth and its pointer widths
   localparam int MAX_DIGITS     = 32;
   localparam int DEPTH_BITS     = $clog2(MAX_DIGITS + 1);
   localparam int STACK_IDX_BITS = $clog2(MAX_DIGITS);

   // Radix register width, bounds and reset value
   localparam int RADIX_BITS          = 5;
   localparam logic [4:0] RADIX_MIN   = 5'd2;
   localparam logic [4:0] RADIX_MAX   = 5'd16;
   localparam logic [4:0] RADIX_RESET = 5'd2;

   // Digit and reciprocal widths
   localparam int DIGIT_BITS = 4;
   localparam int RECIP_BITS = 32;
   localparam int REM_BITS   = 6;

   typedef logic [DIGIT_BITS-1:0] digit_type;

   // Clamp a raw radix code into the supported range
   function automatic logic [4:0] clamp_radix(input logic [4:0] raw);
      logic [4:0] r;
      r = raw;
      if (r < RADIX_MIN) begin
         r = RADIX_MIN;
      end
      if (r > RADIX_MAX) begin
         r = RADIX_MAX;
      end
      return r;
   endfunction

   // floor(2^32 / r) for r in 2..16; the quotient estimate is then at most one low
   function automatic logic [RECIP_BITS-1:0] radix_recip(input logic [4:0] r);
      logic [RECIP_BITS-1:0] m;
      case (r)
         5'd2:    m = 32'h8000_0000;
         5'd3:    m = 32'h5555_5555;
         5'd4:    m = 32'h4000_0000;
         5'd5:    m = 32'h3333_3333;
         5'd6:    m = 32'h2AAA_AAAA;
         5'd7:    m = 32'h2492_4924;
         5'd8:    m = 32'h2000_0000;
         5'd9:    m = 32'h1C71_C71C;
         5'd10:   m = 32'h1999_9999;
         5'd11:   m = 32'h1745_D174;
         5'd12:   m = 32'h1555_5555;
         5'd13:   m = 32'h13B1_3B13;
         5'd14:   m = 32'h1249_2492;
         5'd15:   m = 32'h1111_1111;
         5'd16:   m = 32'h1000_0000;
         default: m = 32'h8000_0000;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

>>> hdl/radix_digit_converter_unit.sv
// Radix digit converter: unsigned integer to a stream of base-N digits, MSD first.
//
// Usage:
//   req channel: one unsigned value per transfer (low VALUE_BITS bits used).
//   rsp channel: one transfer per digit, most significant first; tlast marks
//   the least significant digit. A value of zero yields a single digit 0.
//   csr port: write csr_wr_data into the radix register while idle; codes 0..1
//   act as radix 2 and 17..31 as radix 16. Reset sets radix 2.
// Sequence, for a value with D digits in the chosen radix:
//   the accepting edge loads the value, then each digit takes a multiply step and
//   a correct step in the shared multiply-by-reciprocal divider, then the digit
//   stack is popped into the output register, most significant first; D is at most 32.
//   req_tready is high only while the sequencer is idle and returns on the edge
//   that loads the last digit into the output register, so the next value may be
//   taken while the final digit still waits in the output register.
// Stall: a low rsp_tready freezes the output register and the digit pop.
// Reset: synchronous; clears the sequencer and output valid, and sets the radix register to 2.
`default_nettype none

module radix_digit_converter_unit
   import rdc_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   // Result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [3:0] digit, [7:4] zero
   output logic             rsp_tlast,   // last_digit
   // Configuration
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data  // radix
);

   localparam int W = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
   localparam int PROD_BITS = W + RECIP_BITS;
   localparam int QR_BITS   = W + RADIX_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_FIX,
      ST_EMIT
   } state_type;

   state_type                 state_ff, state_in;
   logic [4:0]                radix_ff, radix_in;
   logic [4:0]                rad_ff, rad_in;
   logic [W-1:0]              value_ff, value_in;
   logic [PROD_BITS-1:0]      prod_ff, prod_in;
   logic [DEPTH_BITS-1:0]     depth_ff, depth_in;
   digit_type                 stack_ff [MAX_DIGITS];
   digit_type                 stack_in [MAX_DIGITS];
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   digit_type                 rsp_digit_ff, rsp_digit_in;
   logic                      rsp_tlast_ff, rsp_tlast_in;

   // Divider correction step signals
   logic [W-1:0]              q_est;
   logic [QR_BITS-1:0]        q_times_r;
   logic [QR_BITS-1:0]        diff;
   logic [REM_BITS-1:0]       rem_est;
   logic                      corr;
   digit_type                 fix_digit;
   logic [W-1:0]              q_fixed;
   logic [DEPTH_BITS-1:0]     depth_inc;
   logic [DEPTH_BITS-1:0]     depth_dec;
   logic                      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(8 - DIGIT_BITS){1'b0}}, rsp_digit_ff};
   assign rsp_tlast  = rsp_tlast_ff;

   // Correct the reciprocal quotient estimate by at most one, step the stack pointer and flag a free output
   always_comb begin
      q_est     = prod_ff[PROD_BITS-1:RECIP_BITS];
      q_times_r = QR_BITS'(q_est) * QR_BITS'(rad_ff);
      diff      = QR_BITS'(value_ff) - q_times_r;
      rem_est   = diff[REM_BITS-1:0];
      corr      = (rem_est >= REM_BITS'(rad_ff));
      fix_digit = corr ? DIGIT_BITS'(rem_est - REM_BITS'(rad_ff)) : DIGIT_BITS'(rem_est);
      q_fixed   = q_est + W'(corr);
      depth_inc = depth_ff + DEPTH_BITS'(1);
      depth_dec = depth_ff - DEPTH_BITS'(1);
      out_free  = !rsp_tvalid_ff || rsp_tready;
   end

   // Sequencer next-state logic
   always_comb begin
      state_in      = state_ff;
      radix_in      = radix_ff;
      rad_in        = rad_ff;
      value_in      = value_ff;
      prod_in       = prod_ff;
      depth_in      = depth_ff;
      stack_in      = stack_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_digit_in  = rsp_digit_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      // Drop the output once its transfer completes
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      if (csr_wr_en) begin
         radix_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               value_in = req_tdata[W-1:0];
               rad_in   = clamp_radix(radix_ff);
               depth_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_BITS'(value_ff) * PROD_BITS'(radix_recip(rad_ff));
            state_in = ST_FIX;
         end
         ST_FIX: begin
            // Push the remainder, keep the quotient
            stack_in[depth_ff[STACK_IDX_BITS-1:0]] = fix_digit;
            depth_in = depth_inc;
            value_in = q_fixed;
            if ((q_fixed == '0) || (depth_inc == DEPTH_BITS'(MAX_DIGITS))) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            // Pop one digit into the output register when it is free
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_digit_in  = stack_ff[depth_dec[STACK_IDX_BITS-1:0]];
               rsp_tlast_in  = (depth_ff == DEPTH_BITS'(1));
               depth_in      = depth_dec;
               if (depth_ff == DEPTH_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, datapath and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         radix_ff      <= RADIX_RESET;
         depth_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         radix_ff      <= radix_in;
         depth_ff      <= depth_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rad_ff       <= rad_in;
      value_ff     <= value_in;
      prod_ff      <= prod_in;
      stack_ff     <= stack_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   // Stack pointer stays within the digit stack
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_BITS'(MAX_DIGITS))
      else $error("digit stack pointer out of range");

   // An accepted value starts the divider
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_MUL))
      else $error("accepted value did not start the divider");

   // Corrected remainder is a valid digit of the radix
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |-> (5'(fix_digit) < rad_ff))
      else $error("remainder not below radix after correction");

   // Emission never runs on an empty stack
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (depth_ff != '0))
      else $error("emit with empty digit stack");

endmodule

`default_nettype wire

>>> test/tb_radix_digit_converter_unit.sv
// Self-checking stream testbench for the radix digit converter unit.
module tb_radix_digit_converter_unit
   import rdc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // One expected digit transfer on the result channel
   typedef struct packed {
      digit_type digit;
      logic      last_digit;
   } digit_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // [31:0] value
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;          // [3:0] digit, [7:4] zero
   logic        rsp_tlast;          // last_digit
   logic        csr_wr_en   = 1'b0;
   logic [4:0]  csr_wr_data = '0;   // radix

   // Shadow of the radix register as last written
   logic [4:0]       radix_code = RADIX_RESET;
   logic [31:0]      pending_values[$];
   digit_result_type expected_digits[$];
   int               sender_idle_pct   = 38;
   int               receiver_idle_pct = 87;
   logic             hold_go  = 1'b0;
   logic             rsp_hold = 1'b0;
   int               mismatch_count = 0;

   radix_digit_converter_unit #(
      .VALUE_BITS(32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   // Codes below two act as base 2, codes above sixteen as base 16
   function automatic logic [4:0] effective_base(input logic [4:0] code);
      if (code < RADIX_MIN) begin
         return RADIX_MIN;
      end
      if (code > RADIX_MAX) begin
         return RADIX_MAX;
      end
      return code;
   endfunction

   // Split a value into digits and queue them most significant first
   function automatic void predict_digits(input logic [31:0] value);
      logic [31:0] rest;
      logic [31:0] base;
      digit_type   lsd_first[$];
      rest = value;
      base = 32'(effective_base(radix_code));
      do begin
         lsd_first.push_back(digit_type'(rest % base));
         rest = rest / base;
      end while (rest != 0);
      for (int i = lsd_first.size() - 1; i >= 0; i--) begin
         expected_digits.push_back('{digit: lsd_first[i], last_digit: (i == 0)});
      end
   endfunction

   // Mix of full-range values, short values and digit-count boundaries
   function automatic logic [31:0] random_value();
      logic [31:0] v;
      logic [63:0] power;
      logic [63:0] base;
      int          steps;
      base = 64'(effective_base(radix_code));
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = $urandom >> $urandom_range(0, 31);
         2: v = $urandom_range(0, 40);
         3: v = 32'hFFFF_FFFF >> $urandom_range(0, 31);
         default: begin
            power = 64'd1;
            steps = $urandom_range(1, 31);
            while (steps > 0 && power * base <= 64'hFFFF_FFFF) begin
               power = power * base;
               steps--;
            end
            v = power[31:0] - 32'($urandom_range(0, 1));
         end
      endcase
      return v;
   endfunction

   // Write the radix register; only called with the block idle
   task automatic write_radix(input logic [4:0] code);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      radix_code = code;
   endtask

   // Wait until every queued value is taken and every digit has come back
   task automatic drain_results();
      @(negedge clock);
      while (pending_values.size() != 0 || req_tvalid || expected_digits.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   // Request driver: offer queued values, predict on each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_digits(req_tdata);
         end
         if (pending_values.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_tdata  <= pending_values.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor: compare each digit transfer with the oldest expectation
   always @(posedge clock) begin : result_monitor
      digit_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_digits.size() == 0) begin
               $display("%0t: unexpected digit transfer: expected none, got digit %0h last %0b",
                        $time, rsp_tdata[3:0], rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_digits.pop_front();
               if (rsp_tdata[3:0] !== want.digit) begin
                  $display("%0t: digit mismatch: expected %0h, got %0h",
                           $time, want.digit, rsp_tdata[3:0]);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.last_digit) begin
                  $display("%0t: last_digit mismatch: expected %0b, got %0b",
                           $time, want.last_digit, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= !rsp_hold && ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Long receiver hold-off, counted here once triggered
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Stimulus: directed values per radix, then random phases
   initial begin
      logic [4:0] radix_sweep[8];
      radix_sweep = '{5'd16, 5'd0, 5'd31, 5'd10, 5'd1, 5'd17, 5'd3, 5'd7};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset radix is base 2
      pending_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000,
                         32'h5555_5555, 32'hAAAA_AAAA};
      drain_results();
      write_radix(5'd16);
      pending_values = '{32'd0, 32'hFFFF_FFFF, 32'h89AB_CDEF, 32'd15, 32'd16};
      drain_results();
      // Out-of-range codes clamp to the nearest supported base
      write_radix(5'd0);
      pending_values.push_back(32'd6);
      drain_results();
      write_radix(5'd1);
      pending_values.push_back(32'd7);
      drain_results();
      write_radix(5'd31);
      pending_values.push_back(32'h0123_4567);
      drain_results();
      write_radix(5'd17);
      pending_values.push_back(32'd255);
      drain_results();
      write_radix(5'd3);
      pending_values = '{32'hFFFF_FFFF, 32'd8};
      drain_results();
      write_radix(5'd10);
      pending_values = '{32'hFFFF_FFFF, 32'd9, 32'd10, 32'd1_000_000_000};
      drain_results();

      for (int phase = 0; phase < 12; phase++) begin
         if (phase < 4) begin
            sender_idle_pct   = 38;
            receiver_idle_pct = 87;
         end else if (phase < 8) begin
            sender_idle_pct   = 87;
            receiver_idle_pct = 38;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         write_radix(phase < 8 ? radix_sweep[phase] : 5'($urandom_range(0, 31)));
         // Stall the result side while the sender keeps offering
         if (phase == 9) begin
            hold_go = 1'b1;
         end
         repeat (32) pending_values.push_back(random_value());
         drain_results();
      end

      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_radix_digit_converter_unit OK");
      end else begin
         $display("tb_radix_digit_converter_unit NOT OK");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("tb_radix_digit_converter_unit NOT OK");
      $finish;
   end

endmodule
